// ===== src/barycentric_weights_3d_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barycentric weights block
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_WEIGHTS_3D_TOP_DEFINES_SVH
`define BARYCENTRIC_WEIGHTS_3D_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define BW3D_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BW3D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BW3D_ASSERT(lbl, expr, msg)
`define BW3D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/bw3d_pkg.sv =====
// ----------------------------------------------------------------------------
// bw3d_pkg
// Fixed widths and limits of the barycentric weights datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bw3d_pkg;

    localparam int COORD_W   = 24;   // input coordinate
    localparam int NUM_FLD   = 12;   // coordinates per beat
    localparam int DIFF_W    = 25;   // b - a etc.
    localparam int PROD_W    = 50;   // diff * diff
    localparam int DOT_W     = 51;   // dot product, signed
    localparam int MAG_W     = 50;   // dot product magnitude
    localparam int HALF_W    = 25;   // split for partial products
    localparam int PP_W      = 50;   // partial product
    localparam int WIDE_W    = 100;  // dot * dot magnitude, also den
    localparam int SW_W      = 101;  // signed dot * dot
    localparam int NUM_W     = 102;  // signed numerator
    localparam int NMAG_W    = 101;  // numerator magnitude
    localparam int QB        = 34;   // quotient bits kept (one rounding bit)
    localparam int WEIGHT_W  = 32;
    localparam int WA_W      = 34;   // room for one - wb - wc
    localparam int NUM_DOT   = 5;
    localparam int NUM_PROD  = 6;

    localparam longint LIM_POS = 64'd2147483647;
    localparam longint LIM_NEG = 64'd2147483648;

    // which dot products feed each wide product: den = p0 - p1, nb = p2 - p3, nc = p4 - p5
    // dot order: d00, d01, d11, d20, d21
    localparam logic [2:0] PROD_OPA [NUM_PROD] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd4, 3'd3};
    localparam logic [2:0] PROD_OPB [NUM_PROD] = '{3'd2, 3'd1, 3'd2, 3'd1, 3'd0, 3'd1};

endpackage

`default_nettype wire

// ===== src/barycentric_weights_3d_top.sv =====
// ----------------------------------------------------------------------------
// barycentric_weights_3d_top
// Fixed-point barycentric weights of a point against a 3-D triangle.
// ----------------------------------------------------------------------------
// One beat in per cycle, one result beat out per input beat, in order. The
// pipeline is 9 stages of differences, dot products and wide products built
// from 25x25 partial products, then a 35-stage restoring divider (range check
// plus one quotient bit per stage, both weights side by side), then rounding
// and the final weight/saturation stage, which is the output register. A stall
// on the output side freezes the whole pipeline; no beat is lost or repeated.
// A zero determinant gives zero weights with degenerate set.
`timescale 1ns / 1ps
`default_nettype none
`include "barycentric_weights_3d_top_defines.svh"

module barycentric_weights_3d_top
    import bw3d_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 12,
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z (24 bits each)
    input  wire logic [287:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // weight_a, weight_b, weight_c (32 bits each)
    output logic [95:0]       m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]        m_axis_tuser
);

    // coordinate scale cancels in the ratios; kept for the interface contract
    localparam int CFB    = COORD_FRAC_BITS;
    localparam int NSH_W  = NMAG_W + WEIGHT_FRAC_BITS + 1;
    localparam int RW     = WIDE_W + 1;
    localparam int NST    = 9 + QB + 1 + 2;
    localparam logic [WA_W-1:0] ONE_W = WA_W'(1) << WEIGHT_FRAC_BITS;

    logic adv;
    logic [NST-1:0] vld_reg, vld_next;

    // stage 1: edge vectors
    logic signed [COORD_W-1:0] fld [NUM_FLD];
    logic signed [DIFF_W-1:0]  u_reg [3], v_reg [3], w_reg [3];
    // stage 2: products
    logic signed [PROD_W-1:0]  prod_reg [NUM_DOT*3];
    // stage 3: dots
    logic signed [DOT_W-1:0]   dot_reg [NUM_DOT];
    // stage 4: magnitudes
    logic [MAG_W-1:0]          dmag_reg [NUM_DOT];
    logic                      dneg_reg [NUM_DOT];
    // stage 5: partial products
    logic [PP_W-1:0]           pp_reg [NUM_PROD][4];
    logic                      ps5_reg [NUM_PROD];
    // stage 6: product magnitudes
    logic [WIDE_W-1:0]         pmag_reg [NUM_PROD];
    logic                      ps6_reg [NUM_PROD];
    // stage 7: signed products
    logic signed [SW_W-1:0]    pval_reg [NUM_PROD];
    // stage 8: den and numerators
    logic [WIDE_W-1:0]         den8_reg;
    logic signed [NUM_W-1:0]   num8_reg [2];
    // stage 9: numerator magnitudes
    logic [NMAG_W-1:0]         nmag_reg [2];
    logic                      nneg9_reg [2];
    logic [WIDE_W-1:0]         den9_reg;
    logic                      degen9_reg;
    // divider stages, index 0 is the range check
    logic [WIDE_W-1:0]         dv_r_reg [QB+1][2];
    logic [QB-1:0]             dv_low_reg [QB+1][2];
    logic [QB-1:0]             dv_q_reg [QB+1][2];
    logic                      dv_ovf_reg [QB+1][2];
    logic                      dv_neg_reg [QB+1][2];
    logic [WIDE_W-1:0]         dv_den_reg [QB+1];
    logic                      dv_degen_reg [QB+1];
    logic [WIDE_W-1:0]         dv_r_next [QB+1][2];
    logic [QB-1:0]             dv_low_next [QB+1][2];
    logic [QB-1:0]             dv_q_next [QB+1][2];
    logic                      dv_ovf_next [QB+1][2];
    logic [RW-1:0]             dv_t [QB+1][2];
    logic                      dv_ge [QB+1][2];
    logic [NSH_W-1:0]          nsh [2];
    logic [NSH_W-QB-1:0]       nhi [2];
    // rounding stage
    logic [QB:0]               qp1 [2];
    logic [QB-1:0]             mq [2];
    logic                      sat_w [2];
    logic [WEIGHT_W-1:0]       wt_next [2];
    logic [WEIGHT_W-1:0]       wt_reg [2];
    logic                      satbc_reg;
    logic                      degen_r_reg;
    // output stage
    logic signed [WA_W-1:0]    wa_full;
    logic                      wa_sat;
    logic [WEIGHT_W-1:0]       wa_next;
    logic [95:0]               out_data_reg, out_data_next;
    logic [1:0]                out_user_reg, out_user_next;
    logic [WEIGHT_W-1:0]       wsum;

    assign adv           = ~vld_reg[NST-1] | m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign vld_next      = {vld_reg[NST-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        for (int f = 0; f < NUM_FLD; f++)
        begin
            fld[f] = s_axis_tdata[f*COORD_W +: COORD_W];
        end
    end

    // front end: stages 1 to 9
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DIFF_W'(fld[3+i]) - DIFF_W'(fld[i]);
                v_reg[i] <= DIFF_W'(fld[6+i]) - DIFF_W'(fld[i]);
                w_reg[i] <= DIFF_W'(fld[9+i]) - DIFF_W'(fld[i]);
                prod_reg[0*3+i] <= u_reg[i] * u_reg[i];
                prod_reg[1*3+i] <= u_reg[i] * v_reg[i];
                prod_reg[2*3+i] <= v_reg[i] * v_reg[i];
                prod_reg[3*3+i] <= w_reg[i] * u_reg[i];
                prod_reg[4*3+i] <= w_reg[i] * v_reg[i];
            end
            for (int k = 0; k < NUM_DOT; k++)
            begin
                dot_reg[k]  <= DOT_W'(prod_reg[k*3]) + DOT_W'(prod_reg[k*3+1])
                             + DOT_W'(prod_reg[k*3+2]);
                dneg_reg[k] <= dot_reg[k][DOT_W-1];
                dmag_reg[k] <= dot_reg[k][DOT_W-1] ? MAG_W'(-dot_reg[k])
                                                   : MAG_W'(dot_reg[k]);
            end
            for (int p = 0; p < NUM_PROD; p++)
            begin
                pp_reg[p][0] <= dmag_reg[PROD_OPA[p]][MAG_W-1:HALF_W]
                              * dmag_reg[PROD_OPB[p]][MAG_W-1:HALF_W];
                pp_reg[p][1] <= dmag_reg[PROD_OPA[p]][MAG_W-1:HALF_W]
                              * dmag_reg[PROD_OPB[p]][HALF_W-1:0];
                pp_reg[p][2] <= dmag_reg[PROD_OPA[p]][HALF_W-1:0]
                              * dmag_reg[PROD_OPB[p]][MAG_W-1:HALF_W];
                pp_reg[p][3] <= dmag_reg[PROD_OPA[p]][HALF_W-1:0]
                              * dmag_reg[PROD_OPB[p]][HALF_W-1:0];
                ps5_reg[p]   <= dneg_reg[PROD_OPA[p]] ^ dneg_reg[PROD_OPB[p]];
                pmag_reg[p]  <= (WIDE_W'(pp_reg[p][0]) << (2*HALF_W))
                              + ((WIDE_W'(pp_reg[p][1]) + WIDE_W'(pp_reg[p][2])) << HALF_W)
                              + WIDE_W'(pp_reg[p][3]);
                ps6_reg[p]   <= ps5_reg[p];
                pval_reg[p]  <= ps6_reg[p] ? -SW_W'(pmag_reg[p]) : SW_W'(pmag_reg[p]);
            end
            // den is a Gram determinant, never negative
            den8_reg    <= WIDE_W'(pval_reg[0] - pval_reg[1]);
            num8_reg[0] <= NUM_W'(pval_reg[2]) - NUM_W'(pval_reg[3]);
            num8_reg[1] <= NUM_W'(pval_reg[4]) - NUM_W'(pval_reg[5]);
            for (int n = 0; n < 2; n++)
            begin
                nneg9_reg[n] <= num8_reg[n][NUM_W-1];
                nmag_reg[n]  <= num8_reg[n][NUM_W-1] ? NMAG_W'(-num8_reg[n])
                                                     : NMAG_W'(num8_reg[n]);
            end
            den9_reg   <= den8_reg;
            degen9_reg <= (den8_reg == '0);
        end
    end

    // divider: quotient of |num| * 2^(WFB+1) / den, QB bits, overflow if wider
    always_comb
    begin
        for (int n = 0; n < 2; n++)
        begin
            nsh[n] = {nmag_reg[n], {(WEIGHT_FRAC_BITS+1){1'b0}}};
            nhi[n] = nsh[n][NSH_W-1:QB];
            dv_t[0][n]        = '0;
            dv_ge[0][n]       = 1'b0;
            dv_ovf_next[0][n] = RW'(nhi[n]) >= RW'(den9_reg);
            dv_r_next[0][n]   = WIDE_W'(nhi[n]);
            dv_low_next[0][n] = nsh[n][QB-1:0];
            dv_q_next[0][n]   = '0;
            for (int j = 1; j <= QB; j++)
            begin
                dv_t[j][n]  = {dv_r_reg[j-1][n], dv_low_reg[j-1][n][QB-1]};
                dv_ge[j][n] = dv_t[j][n] >= RW'(dv_den_reg[j-1]);
                dv_r_next[j][n] = dv_ge[j][n] ? WIDE_W'(dv_t[j][n] - RW'(dv_den_reg[j-1]))
                                              : dv_t[j][n][WIDE_W-1:0];
                dv_low_next[j][n] = dv_low_reg[j-1][n] << 1;
                dv_q_next[j][n]   = {dv_q_reg[j-1][n][QB-2:0], dv_ge[j][n]};
                dv_ovf_next[j][n] = dv_ovf_reg[j-1][n];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= QB; j++)
            begin
                for (int n = 0; n < 2; n++)
                begin
                    dv_r_reg[j][n]   <= dv_r_next[j][n];
                    dv_low_reg[j][n] <= dv_low_next[j][n];
                    dv_q_reg[j][n]   <= dv_q_next[j][n];
                    dv_ovf_reg[j][n] <= dv_ovf_next[j][n];
                    dv_neg_reg[j][n] <= (j == 0) ? nneg9_reg[n] : dv_neg_reg[j-1][n];
                end
                dv_den_reg[j]   <= (j == 0) ? den9_reg : dv_den_reg[j-1];
                dv_degen_reg[j] <= (j == 0) ? degen9_reg : dv_degen_reg[j-1];
            end
        end
    end

    // round half away from zero, clip to 32 bits
    always_comb
    begin
        for (int n = 0; n < 2; n++)
        begin
            qp1[n] = (QB+1)'(dv_q_reg[QB][n]) + (QB+1)'(1);
            mq[n]  = qp1[n][QB:1];
            if (dv_neg_reg[QB][n])
            begin
                sat_w[n]   = dv_ovf_reg[QB][n] || (mq[n] > QB'(LIM_NEG));
                wt_next[n] = sat_w[n] ? WEIGHT_W'(LIM_NEG) : -mq[n][WEIGHT_W-1:0];
            end
            else
            begin
                sat_w[n]   = dv_ovf_reg[QB][n] || (mq[n] > QB'(LIM_POS));
                wt_next[n] = sat_w[n] ? WEIGHT_W'(LIM_POS) : mq[n][WEIGHT_W-1:0];
            end
            if (dv_degen_reg[QB])
            begin
                sat_w[n]   = 1'b0;
                wt_next[n] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wt_reg      <= wt_next;
            satbc_reg   <= sat_w[0] | sat_w[1];
            degen_r_reg <= dv_degen_reg[QB];
        end
    end

    // weight of a = one - wb - wc
    always_comb
    begin
        wa_full = $signed(ONE_W) - WA_W'($signed(wt_reg[0])) - WA_W'($signed(wt_reg[1]));
        wa_sat  = (wa_full[WA_W-1:WEIGHT_W-1] != '0) && (wa_full[WA_W-1:WEIGHT_W-1] != '1);
        if (!wa_sat)
        begin
            wa_next = wa_full[WEIGHT_W-1:0];
        end
        else if (wa_full[WA_W-1])
        begin
            wa_next = WEIGHT_W'(LIM_NEG);
        end
        else
        begin
            wa_next = WEIGHT_W'(LIM_POS);
        end
        if (degen_r_reg)
        begin
            out_data_next = '0;
            out_user_next = 2'b01;
        end
        else
        begin
            out_data_next = {wt_reg[1], wt_reg[0], wa_next};
            out_user_next = {satbc_reg | wa_sat, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign wsum = m_axis_tdata[31:0] + m_axis_tdata[63:32] + m_axis_tdata[95:64];

    `BW3D_ASSERT(a_degen_zero, !(m_axis_tvalid && m_axis_tuser[0]) || ((m_axis_tdata == '0) && !m_axis_tuser[1]), "degenerate beat with nonzero weights")
    `BW3D_ASSERT(a_sum_one, !(m_axis_tvalid && (m_axis_tuser == 2'b00)) || (wsum == ONE_W[WEIGHT_W-1:0]), "weights do not sum to one")
    `BW3D_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted beat not in pipeline")
    `BW3D_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(vld_reg), "stall moved pipeline")

endmodule

`default_nettype wire

// ===== sim/barycentric_weights_3d_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_weights_3d_top_test
// Drives triangle/point beats into the weights pipeline under several
// valid/ready idling patterns and checks every result beat in order against a
// wide-integer model of the Cramer's-rule weights, rounding and saturation.
// ----------------------------------------------------------------------------
module barycentric_weights_3d_top_test;
    import bw3d_pkg::*;

    localparam int WFRAC     = 16;
    localparam int WDOG_MAX  = 4000;
    localparam int DRAIN_CYC = 80;
    localparam int HOLD_CYC  = 300;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t tri_pt_t [NUM_FLD];

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] wa;
        logic signed [WEIGHT_W-1:0] wb;
        logic signed [WEIGHT_W-1:0] wc;
        logic                       degen;
        logic                       sat;
    } weights_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    weights_t expected_weights [$];
    int       errors = 0;
    int       idle_pct;
    int       stall_pct;
    int       hold_left = 0;
    bit       hold_req;
    bit       hold_done;
    int       quiet_cycles = 0;

    barycentric_weights_3d_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // rounded n*2^WFRAC/den, ties away from zero, clipped to 32 bits
    function automatic longint divide_weight(logic signed [127:0] num,
                                             logic signed [127:0] den,
                                             inout logic sat);
        logic [159:0] mag;
        logic [159:0] q;
        logic         neg;
        neg = num[127];
        mag = neg ? 160'(-num) : 160'(num);
        q   = (mag << (WFRAC + 1)) / 160'(den);
        q   = (q + 160'd1) >> 1;
        if (neg)
        begin
            if (q > 160'h8000_0000)
            begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(q[63:0]);
        end
        if (q > 160'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(q[63:0]);
    endfunction

    function automatic weights_t predict_weights(tri_pt_t c);
        longint              u [3];
        longint              v [3];
        longint              w [3];
        longint              d00, d01, d11, d20, d21;
        logic signed [127:0] den, nb, nc;
        longint              wa, wb, wc;
        logic                sat;
        weights_t            r;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'(c[3 + i]) - longint'(c[i]);
            v[i] = longint'(c[6 + i]) - longint'(c[i]);
            w[i] = longint'(c[9 + i]) - longint'(c[i]);
        end
        d00 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        d01 = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        d11 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        d20 = w[0] * u[0] + w[1] * u[1] + w[2] * u[2];
        d21 = w[0] * v[0] + w[1] * v[1] + w[2] * v[2];
        den = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
        nb  = 128'(d20) * 128'(d11) - 128'(d21) * 128'(d01);
        nc  = 128'(d21) * 128'(d00) - 128'(d20) * 128'(d01);
        sat = 1'b0;
        r   = '0;
        if (den == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        wb = divide_weight(nb, den, sat);
        wc = divide_weight(nc, den, sat);
        wa = (64'sd1 <<< WFRAC) - wb - wc;
        if (wa > 64'sd2147483647)
        begin
            wa  = 64'sd2147483647;
            sat = 1'b1;
        end
        if (wa < -64'sd2147483648)
        begin
            wa  = -64'sd2147483648;
            sat = 1'b1;
        end
        r.wa  = wa[31:0];
        r.wb  = wb[31:0];
        r.wc  = wc[31:0];
        r.sat = sat;
        return r;
    endfunction

    // one input beat; idles first with the current sender idle rate
    task automatic send_triangle(tri_pt_t c);
        logic         ok;
        logic [287:0] beat;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < NUM_FLD; i++)
            beat[i * COORD_W +: COORD_W] = c[i];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        expected_weights.push_back(predict_weights(c));
    endtask

    task automatic send_axes(int k, int px, int py, int pz);
        tri_pt_t c;
        foreach (c[i])
            c[i] = '0;
        c[3]  = coord_t'(k);
        c[7]  = coord_t'(k);
        c[9]  = coord_t'(px);
        c[10] = coord_t'(py);
        c[11] = coord_t'(pz);
        send_triangle(c);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(16) - 8);
            2: return coord_t'($urandom_range(8000) - 4000);
            default: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic tri_pt_t rand_triangle();
        tri_pt_t c;
        int      mode;
        int      shape;
        mode  = $urandom_range(3);
        shape = $urandom_range(9);
        foreach (c[i])
            c[i] = rand_coord($urandom_range(9) == 0 ? 3 : mode);
        if (shape == 0)
        begin
            // collinear: c = a + 2*(b - a) for small values
            for (int i = 0; i < 3; i++)
            begin
                c[i]     = rand_coord(2);
                c[3 + i] = rand_coord(2);
                c[6 + i] = coord_t'(2 * c[3 + i] - c[i]);
            end
        end
        else if (shape == 1)
        begin
            // tiny triangle, far point: drives saturation
            for (int i = 0; i < 9; i++)
                c[i] = rand_coord(1);
        end
        return c;
    endfunction

    task automatic send_directed();
        tri_pt_t c;
        foreach (c[i])
            c[i] = '0;
        send_triangle(c);
        foreach (c[i])
            c[i] = 24'sh7FFFFF;
        send_triangle(c);
        foreach (c[i])
            c[i] = 24'sh800000;
        send_triangle(c);
        foreach (c[i])
            c[i] = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
        send_triangle(c);
        foreach (c[i])
            c[i] = (i % 3 == 0) ? 24'sh800000 : ((i % 3 == 1) ? 24'sh7FFFFF : 24'sh0);
        send_triangle(c);
        // p at each vertex and at the middle
        send_axes(4096, 0, 0, 0);
        send_axes(4096, 4096, 0, 0);
        send_axes(4096, 0, 4096, 0);
        send_axes(4096, 1365, 1365, 7);
        // half-way rounding ties, both signs
        send_axes(1 << 17, 1, 0, 0);
        send_axes(1 << 17, -1, 0, 0);
        send_axes(1 << 17, 3, -3, 0);
        // weights clipped high and low
        send_axes(1, 8388607, 0, 0);
        send_axes(1, -8388608, 8388607, 0);
        send_axes(1, 8388607, 8388607, 5);
        send_axes(1, -8388608, -8388608, 0);
        send_axes(8388607, -8388608, -8388608, 0);
        // widest legal edges
        send_axes(-8388608, 8388607, -8388608, 8388607);
        // coincident vertices
        foreach (c[i])
            c[i] = (i < 9) ? 24'sh001234 : coord_t'($urandom);
        send_triangle(c);
    endtask

    task automatic test_random(int items, int idle_rate, int stall_rate);
        idle_pct  = idle_rate;
        stall_pct = stall_rate;
        for (int n = 0; n < items; n++)
            send_triangle(rand_triangle());
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int n = 0; n < 80; n++)
            send_triangle(rand_triangle());
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left     <= HOLD_CYC - 1;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result beats are settled at the falling edge before they are taken
    always @(negedge clk)
    begin
        weights_t got;
        weights_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tuser[0], m_axis_tuser[1]};
            if (expected_weights.size() == 0)
            begin
                errors++;
                $display("%t unexpected beat: actual %h", $realtime, got);
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                if (got.wa !== exp_w.wa)
                    $display("%t weight_a expected %0d actual %0d", $realtime, exp_w.wa, got.wa);
                if (got.wb !== exp_w.wb)
                    $display("%t weight_b expected %0d actual %0d", $realtime, exp_w.wb, got.wb);
                if (got.wc !== exp_w.wc)
                    $display("%t weight_c expected %0d actual %0d", $realtime, exp_w.wc, got.wc);
                if (got.degen !== exp_w.degen)
                    $display("%t degenerate expected %b actual %b", $realtime,
                             exp_w.degen, got.degen);
                if (got.sat !== exp_w.sat)
                    $display("%t saturated expected %b actual %b", $realtime, exp_w.sat, got.sat);
                if (got !== exp_w)
                    errors++;
            end
        end
    end

    // watchdog: cycles with no beat accepted on either side
    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("barycentric_weights_3d_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        test_random(100, 0, 0);
        test_random(140, 48, 0);
        test_random(140, 0, 48);
        test_random(140, 10, 10);
        test_backpressure();
        test_random(30, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && expected_weights.size() == 0)
            $display("barycentric_weights_3d_top_test OK");
        else
            $display("barycentric_weights_3d_top_test NOT OK");
        $finish;
    end

endmodule
